// ----- hdl/sfd_pkg.sv -----
// ----------------------------------------------------------------------------
// sfd_pkg : shared types and constants for the serial frame deframer
// Field widths, configuration register indexes, message classes and the
// parser phase encoding.
// ----------------------------------------------------------------------------
package sfd_pkg;

    localparam int BYTE_W        = 8;
    localparam int ID_W          = 16;
    localparam int PAYLOAD_BYTES = 7;
    localparam int PAYLOAD_W     = PAYLOAD_BYTES * BYTE_W;
    localparam int CLASS_W       = 2;
    localparam int CFG_INDEX_W   = 3;
    localparam int CFG_DATA_W    = 16;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_HEADER_BYTE    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TRAILER_FIRST  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TRAILER_SECOND = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ANGLE_COMMAND  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPEED_COMMAND  = 3'd4;

    // Message classes
    localparam logic [CLASS_W-1:0] CLASS_ANGLE = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_SPEED = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_OTHER = 2'd2;

    // Parser phases
    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_ID_LO   = 3'd1,
        PH_ID_HI   = 3'd2,
        PH_HEADER2 = 3'd3,
        PH_BODY    = 3'd4,
        PH_TRAIL   = 3'd5
    } phase_t;

endpackage

// ----- hdl/serial_frame_deframer.sv -----
// ----------------------------------------------------------------------------
// serial_frame_deframer : header / two-byte trailer byte frame parser
// Hunts for a header byte, takes a little-endian command id, checks a second
// header byte, gathers body bytes up to a two-byte trailer, and emits one
// transaction per frame of exactly ACCEPT_LENGTH stored bytes.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready, rx_byte): one received byte per
//    transaction. Output channel (out_valid/out_ready): command_id, payload
//    (seven bytes after the id, earliest in the low byte) and message_class.
//  - Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data): cfg_ready
//    is always high; write registers only while no bytes are in flight.
//  - An accepted byte waits in the input register and is parsed once the
//    result register is free; a frame it completes is then registered there.
//  - Throughput: one byte per cycle when not stalled. Each byte passes
//    through an input register, one shallow parse step and the result register.
//  - Output stall: the input register keeps taking a byte while the result
//    register is empty or being drained; with a full result register and
//    out_ready low, one further byte is held and in_ready then drops.
//  - Reset (rst_n low, asynchronous): parser back to header hunt, fill count
//    and valid flags cleared, all configuration registers zero. The byte
//    store needs no clearing: an accepted frame has written every kept byte.
// ----------------------------------------------------------------------------
module serial_frame_deframer
    import sfd_pkg::*;
#(
    parameter int STORE_BYTES   = 20,
    parameter int ACCEPT_LENGTH = 10
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // byte input channel
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [BYTE_W-1:0]      rx_byte,
    // frame output channel
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [ID_W-1:0]        command_id,
    output logic [PAYLOAD_W-1:0]   payload,
    output logic [CLASS_W-1:0]     message_class
);

    // Fill count must reach STORE_BYTES and compare against every store entry
    localparam int FILL_MAX = (STORE_BYTES > ACCEPT_LENGTH) ? STORE_BYTES : ACCEPT_LENGTH;
    localparam int FILL_W   = $clog2(FILL_MAX + 1);

    // ---------------- configuration registers ----------------
    logic [BYTE_W-1:0] header_byte_reg;
    logic [BYTE_W-1:0] trailer_first_reg;
    logic [BYTE_W-1:0] trailer_second_reg;
    logic [ID_W-1:0]   angle_command_reg;
    logic [ID_W-1:0]   speed_command_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_byte_reg    <= '0;
            trailer_first_reg  <= '0;
            trailer_second_reg <= '0;
            angle_command_reg  <= '0;
            speed_command_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_HEADER_BYTE:    header_byte_reg    <= cfg_data[BYTE_W-1:0];
                CFG_TRAILER_FIRST:  trailer_first_reg  <= cfg_data[BYTE_W-1:0];
                CFG_TRAILER_SECOND: trailer_second_reg <= cfg_data[BYTE_W-1:0];
                CFG_ANGLE_COMMAND:  angle_command_reg  <= cfg_data[ID_W-1:0];
                CFG_SPEED_COMMAND:  speed_command_reg  <= cfg_data[ID_W-1:0];
                default:            ; // unmapped index: ignored
            endcase
        end
    end

    // ---------------- input register ----------------
    logic              in_valid_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic              out_valid_reg;
    logic              advance;   // result register free this cycle
    logic              step;      // a held byte is parsed this cycle

    assign advance  = !out_valid_reg || out_ready;
    assign step     = in_valid_reg && advance;
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= rx_byte;
        end
    end

    // ---------------- parser state ----------------
    phase_t            phase_reg;
    phase_t            phase_next;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic [FILL_W-1:0] fill_plus1;
    logic [BYTE_W-1:0] store_reg [ACCEPT_LENGTH];

    logic is_header;
    logic is_trail1;
    logic is_trail2;
    logic body_room;   // room for one more body byte
    logic pair_room;   // room for a kept trailer_first plus the byte after it
    logic len_ok;

    assign is_header  = (byte_reg == header_byte_reg);
    assign is_trail1  = (byte_reg == trailer_first_reg);
    assign is_trail2  = (byte_reg == trailer_second_reg);
    assign fill_plus1 = fill_reg + FILL_W'(1);
    assign body_room  = (fill_reg < FILL_W'(STORE_BYTES - 1));
    assign pair_room  = (({1'b0, fill_reg} + (FILL_W+1)'(2)) <= (FILL_W+1)'(STORE_BYTES));
    assign len_ok     = (fill_reg == FILL_W'(ACCEPT_LENGTH));

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_HUNT:    phase_next = is_header ? PH_ID_LO : PH_HUNT;
            PH_ID_LO:   phase_next = PH_ID_HI;
            PH_ID_HI:   phase_next = PH_HEADER2;
            PH_HEADER2: phase_next = is_header ? PH_BODY : PH_HUNT;
            PH_BODY:
            begin
                if (is_trail1)
                    phase_next = PH_TRAIL;
                else if (body_room)
                    phase_next = PH_BODY;
                else
                    phase_next = PH_HUNT;
            end
            PH_TRAIL:
            begin
                if (!is_trail2 && pair_room)
                    phase_next = PH_BODY;
                else
                    phase_next = PH_HUNT;
            end
            default:    phase_next = PH_HUNT;
        endcase
    end

    // fill count, store writes and frame completion
    logic              wr_a;       // write data_a at fill
    logic              wr_b;       // write byte at fill + 1
    logic [BYTE_W-1:0] data_a;
    logic              frame_done;

    always_comb
    begin
        fill_next  = fill_reg;
        wr_a       = 1'b0;
        wr_b       = 1'b0;
        data_a     = byte_reg;
        frame_done = 1'b0;
        case (phase_reg)
            PH_HUNT:
            begin
                fill_next = '0;
            end
            PH_ID_LO, PH_ID_HI:
            begin
                wr_a      = 1'b1;
                fill_next = fill_plus1;
            end
            PH_HEADER2:
            begin
                if (is_header)
                begin
                    wr_a      = 1'b1;
                    fill_next = fill_plus1;
                end
                else
                begin
                    fill_next = '0;
                end
            end
            PH_BODY:
            begin
                if (!is_trail1)
                begin
                    if (body_room)
                    begin
                        wr_a      = 1'b1;
                        fill_next = fill_plus1;
                    end
                    else
                    begin
                        fill_next = '0;
                    end
                end
            end
            PH_TRAIL:
            begin
                if (is_trail2)
                begin
                    frame_done = len_ok;
                    fill_next  = '0;
                end
                else if (pair_room)
                begin
                    // false trailer: keep trailer_first and this byte as data
                    wr_a      = 1'b1;
                    wr_b      = 1'b1;
                    data_a    = trailer_first_reg;
                    fill_next = fill_reg + FILL_W'(2);
                end
                else
                begin
                    fill_next = '0;
                end
            end
            default:
            begin
                fill_next = fill_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            fill_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            fill_reg  <= fill_next;
        end
    end

    // byte store: only positions below ACCEPT_LENGTH are kept
    always_ff @(posedge clk)
    begin
        for (int e = 0; e < ACCEPT_LENGTH; e++)
        begin
            if (step && wr_a && (fill_reg == FILL_W'(e)))
                store_reg[e] <= data_a;
            else if (step && wr_b && (fill_plus1 == FILL_W'(e)))
                store_reg[e] <= byte_reg;
        end
    end

    // ---------------- result assembly ----------------
    logic [ID_W-1:0]      id_now;
    logic [BYTE_W-1:0]    pay_bytes [PAYLOAD_BYTES];
    logic [PAYLOAD_W-1:0] payload_now;
    logic [CLASS_W-1:0]   class_now;

    assign id_now = {store_reg[1], store_reg[0]};

    for (genvar i = 0; i < PAYLOAD_BYTES; i++)
    begin : g_pay
        if (i + 2 < ACCEPT_LENGTH)
        begin : g_kept
            assign pay_bytes[i] = store_reg[i+2];
        end
        else
        begin : g_zero
            assign pay_bytes[i] = '0;
        end
        assign payload_now[BYTE_W*i +: BYTE_W] = pay_bytes[i];
    end

    // angle id wins when both ids match
    always_comb
    begin
        if (id_now == angle_command_reg)
            class_now = CLASS_ANGLE;
        else if (id_now == speed_command_reg)
            class_now = CLASS_SPEED;
        else
            class_now = CLASS_OTHER;
    end

    // ---------------- result register ----------------
    logic [ID_W-1:0]      command_id_reg;
    logic [PAYLOAD_W-1:0] payload_reg;
    logic [CLASS_W-1:0]   class_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= step && frame_done;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && frame_done)
        begin
            command_id_reg <= id_now;
            payload_reg    <= payload_now;
            class_reg      <= class_now;
        end
    end

    assign out_valid     = out_valid_reg;
    assign command_id    = command_id_reg;
    assign payload       = payload_reg;
    assign message_class = class_reg;

endmodule

// ----- hdl/sfd_checker.sv -----
// ----------------------------------------------------------------------------
// sfd_checker : port-level checks for the serial frame deframer
// Watches the top-level ports and flags handshake and latency slips.
// ----------------------------------------------------------------------------
module sfd_checker
    import sfd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic [ID_W-1:0]      command_id,
    input  logic [PAYLOAD_W-1:0] payload,
    input  logic [CLASS_W-1:0]   message_class
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(command_id)
            && $stable(payload) && $stable(message_class)))
        else $error("stalled result changed or dropped");

    // class code is one of the three defined values
    a_class_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (message_class == CLASS_ANGLE || message_class == CLASS_SPEED
            || message_class == CLASS_OTHER))
        else $error("undefined message class");

    // an empty result register never blocks the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    // a new result follows an earlier byte transaction
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result without preceding byte");

endmodule

bind serial_frame_deframer sfd_checker u_sfd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .command_id    (command_id),
    .payload       (payload),
    .message_class (message_class)
);

// ----- tb/serial_frame_deframer_tb.sv -----
// ----------------------------------------------------------------------------
// serial_frame_deframer_tb : self-checking bench for the byte frame deframer
// Streams received bytes through the block under several register settings
// and idle patterns. A cycle-free mirror of the parser predicts every frame
// the block should emit; emitted frames are compared field by field in order.
// ----------------------------------------------------------------------------
module serial_frame_deframer_tb
    import sfd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_BYTES   = 20;
    localparam int ACCEPT_LENGTH = 10;
    localparam int RANDOM_BYTES  = 180;   // per register setting
    localparam int STALL_LIMIT   = 2000;  // cycles without any transaction
    localparam int SETTLE_CYCLES = 8;     // margin for bytes still in the pipeline
    localparam int REPORT_LIMIT  = 10;

    // One emitted frame as seen on the output channel
    typedef struct {
        logic [ID_W-1:0]      id;
        logic [PAYLOAD_W-1:0] body;
        logic [CLASS_W-1:0]   cls;
    } frame_result_t;

    // Mirror of the parser: register copies, parse state and the queue of
    // frames still owed by the block.
    class deframer_mirror;
        logic [BYTE_W-1:0] hdr;
        logic [BYTE_W-1:0] trail_a;
        logic [BYTE_W-1:0] trail_b;
        logic [ID_W-1:0]   angle_id;
        logic [ID_W-1:0]   speed_id;
        phase_t            phase;
        int unsigned       stored;
        logic [BYTE_W-1:0] kept [ACCEPT_LENGTH];
        frame_result_t     owed_frames [$];
        int unsigned       mismatches;

        function new();
            hdr        = '0;
            trail_a    = '0;
            trail_b    = '0;
            angle_id   = '0;
            speed_id   = '0;
            mismatches = 0;
            drop_frame();
        endfunction

        function void drop_frame();
            phase  = PH_HUNT;
            stored = 0;
            foreach (kept[i])
                kept[i] = '0;
        endfunction

        // bytes past the kept window are counted only
        function void keep(logic [BYTE_W-1:0] b);
            if (stored < ACCEPT_LENGTH)
                kept[stored] = b;
            stored++;
        endfunction

        function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_HEADER_BYTE:    hdr      = data[BYTE_W-1:0];
                CFG_TRAILER_FIRST:  trail_a  = data[BYTE_W-1:0];
                CFG_TRAILER_SECOND: trail_b  = data[BYTE_W-1:0];
                CFG_ANGLE_COMMAND:  angle_id = data[ID_W-1:0];
                CFG_SPEED_COMMAND:  speed_id = data[ID_W-1:0];
                default: ;
            endcase
        endfunction

        // Called for every byte the block accepts
        function void take_byte(logic [BYTE_W-1:0] b);
            frame_result_t f;
            case (phase)
                PH_HUNT:
                    if (b == hdr) begin
                        stored = 0;
                        phase  = PH_ID_LO;
                    end
                    else
                        drop_frame();
                PH_ID_LO:
                begin
                    keep(b);
                    phase = PH_ID_HI;
                end
                PH_ID_HI:
                begin
                    keep(b);
                    phase = PH_HEADER2;
                end
                PH_HEADER2:
                    if (b == hdr) begin
                        keep(b);
                        phase = PH_BODY;
                    end
                    else
                        drop_frame();
                PH_BODY:
                    if (b != trail_a) begin
                        if (stored < STORE_BYTES - 1)
                            keep(b);
                        else
                            drop_frame();
                    end
                    else
                        phase = PH_TRAIL;
                PH_TRAIL:
                    if (b == trail_b) begin
                        if (stored == ACCEPT_LENGTH) begin
                            f.id   = {kept[1], kept[0]};
                            f.body = '0;
                            for (int i = 0; i < PAYLOAD_BYTES; i++)
                                if (2 + i < ACCEPT_LENGTH)
                                    f.body[BYTE_W*i +: BYTE_W] = kept[2 + i];
                            if (f.id == angle_id)
                                f.cls = CLASS_ANGLE;
                            else if (f.id == speed_id)
                                f.cls = CLASS_SPEED;
                            else
                                f.cls = CLASS_OTHER;
                            owed_frames.push_back(f);
                        end
                        drop_frame();
                    end
                    else if (stored + 2 <= STORE_BYTES) begin
                        keep(trail_a);
                        keep(b);
                        phase = PH_BODY;
                    end
                    else
                        drop_frame();
                default:
                    phase = PH_HUNT;
            endcase
        endfunction

        // Called for every frame the block hands over
        function void match_frame(logic [ID_W-1:0] id, logic [PAYLOAD_W-1:0] body,
                                  logic [CLASS_W-1:0] cls);
            frame_result_t want;
            if (owed_frames.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t unexpected frame: id %h payload %h class %0d",
                             $realtime, id, body, cls);
                return;
            end
            want = owed_frames.pop_front();
            if (id !== want.id || body !== want.body || cls !== want.cls) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t frame mismatch: id exp %h got %h, payload exp %h got %h, %s",
                             $realtime, want.id, id, want.body, body,
                             $sformatf("class exp %0d got %0d", want.cls, cls));
            end
        endfunction

        function int pending();
            return owed_frames.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals. Every block input holds a known value from time zero.
    // ------------------------------------------------------------------------
    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [BYTE_W-1:0]      rx_byte = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [ID_W-1:0]        command_id;
    logic [PAYLOAD_W-1:0]   payload;
    logic [CLASS_W-1:0]     message_class;

    deframer_mirror    mirror = new();
    logic [BYTE_W-1:0] burst [$];       // bytes queued for the input channel
    int                send_idle_pct = 0;
    int                recv_idle_pct = 0;
    int                setting_bytes = 0;
    int                quiet_cycles  = 0;

    serial_frame_deframer #(
        .STORE_BYTES   (STORE_BYTES),
        .ACCEPT_LENGTH (ACCEPT_LENGTH)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .command_id    (command_id),
        .payload       (payload),
        .message_class (message_class)
    );

    always #10 clk = ~clk;

    // Receiver: ready drops at random at the chosen idle rate
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    // Output monitor. Sampling straight after the edge sees the values the
    // block held at that edge, so the handshake is read race-free.
    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            mirror.match_frame(command_id, payload, message_class);

    // Watchdog: any transaction on any channel restarts the count
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // One byte transaction; random idle cycles go in front of it. Valid is
    // left high after acceptance so back-to-back bytes never toggle it.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        mirror.take_byte(b);
        setting_bytes++;
    endtask

    task automatic send_burst();
        while (burst.size() > 0)
            send_byte(burst.pop_front());
    endtask

    // Drop valid, let every owed frame come out, then allow for bytes still in
    // the pipeline that produce nothing.
    task automatic wait_quiet();
        in_valid <= 1'b0;
        @(posedge clk);
        while (mirror.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes all five registers; valid stays high across the writes. The spare
    // upper bits of the byte-wide registers carry junk that must be ignored.
    task automatic configure(input logic [BYTE_W-1:0] hdr, tf, ts,
                             input logic [ID_W-1:0] ang, spd);
        logic [CFG_INDEX_W-1:0] idx [5];
        logic [CFG_DATA_W-1:0]  val [5];
        idx = '{CFG_HEADER_BYTE, CFG_TRAILER_FIRST, CFG_TRAILER_SECOND,
                CFG_ANGLE_COMMAND, CFG_SPEED_COMMAND};
        val = '{{8'($urandom), hdr}, {8'($urandom), tf}, {8'($urandom), ts}, ang, spd};
        for (int i = 0; i < 5; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            mirror.set_reg(idx[i], val[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------------

    function automatic logic [BYTE_W-1:0] any_but(input logic [BYTE_W-1:0] v);
        logic [BYTE_W-1:0] r;
        r = BYTE_W'($urandom);
        while (r == v)
            r = BYTE_W'($urandom);
        return r;
    endfunction

    // Frame of header, id, second header (or a wrong byte), body_len stored
    // body bytes, and optionally the trailer. A kept trailer_first/other pair
    // may sit inside the body and counts as two stored bytes.
    function automatic void push_frame(input int body_len, input bit hdr2_ok,
                                       input bit with_pair, input bit close);
        logic [ID_W-1:0] id;
        int              pair_at;
        int              i;
        case ($urandom_range(2))
            0:       id = mirror.angle_id;
            1:       id = mirror.speed_id;
            default: id = ID_W'($urandom);
        endcase
        // a pair is only data when the trailer bytes differ
        if (with_pair && body_len >= 2 && mirror.trail_a != mirror.trail_b)
            pair_at = $urandom_range(body_len - 2);
        else
            pair_at = -1;
        burst.push_back(mirror.hdr);
        burst.push_back(id[7:0]);
        burst.push_back(id[15:8]);
        burst.push_back(hdr2_ok ? mirror.hdr : any_but(mirror.hdr));
        i = 0;
        while (i < body_len) begin
            if (i == pair_at) begin
                burst.push_back(mirror.trail_a);
                burst.push_back(any_but(mirror.trail_b));
                i += 2;
            end
            else begin
                burst.push_back(any_but(mirror.trail_a));
                i++;
            end
        end
        if (close) begin
            burst.push_back(mirror.trail_a);
            burst.push_back(mirror.trail_b);
        end
    endfunction

    // Mostly well-formed frames with random content; the rest is broken
    // frames and line noise.
    function automatic void push_random_burst();
        int roll;
        int len;
        roll = $urandom_range(99);
        if (roll < 60)
            push_frame(ACCEPT_LENGTH - 3, 1'b1, ($urandom_range(9) < 3), 1'b1);
        else if (roll < 70) begin
            // wrong length at the trailer
            len = $urandom_range(16);
            if (len == ACCEPT_LENGTH - 3)
                len++;
            push_frame(len, 1'b1, 1'($urandom_range(1)), 1'b1);
        end
        else if (roll < 77)
            // body runs into the end of the store
            push_frame($urandom_range(20, 17), 1'b1, 1'b0, 1'b1);
        else if (roll < 82) begin
            // store almost full, then a kept trailer pair that does not fit
            push_frame(STORE_BYTES - 4, 1'b1, 1'b0, 1'b0);
            burst.push_back(mirror.trail_a);
            burst.push_back(any_but(mirror.trail_b));
            burst.push_back(mirror.trail_a);
            burst.push_back(mirror.trail_b);
        end
        else if (roll < 88)
            // second header missing
            push_frame(ACCEPT_LENGTH - 3, 1'b0, 1'b0, 1'b1);
        else
            repeat ($urandom_range(6, 1)) burst.push_back(8'($urandom));
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence: five register settings, three idle patterns
    // ------------------------------------------------------------------------
    initial
    begin
        logic [BYTE_W-1:0] tf;
        logic [ID_W-1:0]   same_id;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int setting = 0; setting < 5; setting++) begin
            // sender mostly busy first, then receiver, then neither idles
            if (setting < 2) begin
                send_idle_pct = 6;
                recv_idle_pct = 87;
            end
            else if (setting < 4) begin
                send_idle_pct = 87;
                recv_idle_pct = 6;
            end
            else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            if (setting > 0)
                wait_quiet();
            case (setting)
                0: configure(8'hA5, 8'h0D, 8'h0A, 16'h1234, 16'hBEEF);
                // all ones: trailer and header share a value, ids equal
                1: configure(8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);
                2: configure(8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000);
                3: configure(BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom),
                             ID_W'($urandom), ID_W'($urandom));
                default:
                begin
                    tf      = BYTE_W'($urandom);
                    same_id = ID_W'($urandom);
                    configure(BYTE_W'($urandom), tf, any_but(tf), same_id, same_id);
                end
            endcase

            if (setting == 0) begin
                // angle frame carrying a kept trailer pair and both byte extremes
                burst = '{8'hA5, 8'h34, 8'h12, 8'hA5, 8'h00, 8'hFF, 8'h0D, 8'h55,
                          8'h80, 8'h01, 8'h7E, 8'h0D, 8'h0A};
                // second header missing
                burst.push_back(8'hA5);
                burst.push_back(8'hEF);
                burst.push_back(8'hBE);
                burst.push_back(8'h5A);
                // too short at the trailer, dropped silently
                burst.push_back(8'hA5);
                burst.push_back(8'hEF);
                burst.push_back(8'hBE);
                burst.push_back(8'hA5);
                burst.push_back(8'h42);
                burst.push_back(8'h0D);
                burst.push_back(8'h0A);
                send_burst();
            end

            setting_bytes = 0;
            while (setting_bytes < RANDOM_BYTES) begin
                push_random_burst();
                send_burst();
            end
        end

        wait_quiet();
        if (mirror.mismatches == 0 && mirror.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- serial_frame_deframer.f -----
hdl/sfd_pkg.sv
hdl/serial_frame_deframer.sv
hdl/sfd_checker.sv
tb/serial_frame_deframer_tb.sv
